// ===== rtl/swapchain_cycle_predictor_assert.svh =====
// Assertion macros used by the swapchain cycle predictor port-level checker.
`ifndef SWAPCHAIN_CYCLE_PREDICTOR_ASSERT_SVH
`define SWAPCHAIN_CYCLE_PREDICTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scp_pkg.sv =====
// Shared constants, command codes and status struct of the swapchain cycle predictor.
package scp_pkg;

    localparam int TABLE_DEPTH_DEF = 6;
    localparam int ADDR_BITS_DEF   = 32;
    localparam int FRAME_BITS_DEF  = 64;

    localparam int NEED_W = 3;
    localparam int CYC_W  = 3;

    localparam logic [NEED_W-1:0] NEED_RESET = 3'd3;
    localparam logic [CYC_W-1:0]  CYC_MAX    = 3'd7;

    // Commands from the controller to the datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SRCH_RD,
        CMD_NEXT,
        CMD_TRIM,
        CMD_MISS,
        CMD_UPD_SAME,
        CMD_UPD_WR,
        CMD_UPD_CAP,
        CMD_ADV_RD,
        CMD_ADV_CHK,
        CMD_OUT_RD,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic is_upd;
        logic idx_end;
        logic addr_hit;
        logic frame_hit;
        logic cyc_active;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/scp_ctrl.sv =====
// Sequencing state machine of the swapchain cycle predictor.
module scp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_tvalid,
    output logic                o_in_tready,
    input  scp_pkg::t_dp_status i_status,
    output scp_pkg::t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DISP  = 8'b0000_0010,
        S_SRCH  = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_ADV   = 8'b0001_0000,
        S_CHK   = 8'b0010_0000,
        S_OUTRD = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = scp_pkg::CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_tvalid) begin
                    o_cmd   = scp_pkg::CMD_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                // a predict on an established cycle walks the ring, otherwise scan the table
                if (!i_status.is_upd && i_status.cyc_active) begin
                    n_state = S_ADV;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (i_status.idx_end) begin
                    o_cmd   = i_status.is_upd ? scp_pkg::CMD_UPD_CAP : scp_pkg::CMD_MISS;
                    n_state = S_OUTRD;
                end else begin
                    o_cmd   = scp_pkg::CMD_SRCH_RD;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_status.addr_hit) begin
                    o_cmd   = scp_pkg::CMD_NEXT;
                    n_state = S_SRCH;
                end else if (!i_status.is_upd) begin
                    o_cmd   = scp_pkg::CMD_TRIM;
                    n_state = S_OUTRD;
                end else if (i_status.frame_hit) begin
                    o_cmd   = scp_pkg::CMD_UPD_SAME;
                    n_state = S_OUTRD;
                end else begin
                    o_cmd   = scp_pkg::CMD_UPD_WR;
                    n_state = S_OUTRD;
                end
            end
            S_ADV: begin
                o_cmd   = scp_pkg::CMD_ADV_RD;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd   = scp_pkg::CMD_ADV_CHK;
                n_state = S_OUTRD;
            end
            S_OUTRD: begin
                o_cmd   = scp_pkg::CMD_OUT_RD;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register can take the item
                if (i_status.out_free) begin
                    o_cmd   = scp_pkg::CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/scp_dpath.sv =====
// Datapath of the swapchain cycle predictor: sync table memories, cycle state, result register.
module scp_dpath #(
    parameter int TABLE_DEPTH = scp_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_BITS   = scp_pkg::ADDR_BITS_DEF,
    parameter int FRAME_BITS  = scp_pkg::FRAME_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  scp_pkg::t_cmd             i_cmd,
    output scp_pkg::t_dp_status       o_status,
    input  logic                      i_cfg_wr_en,
    input  logic [scp_pkg::NEED_W-1:0] i_cfg_wr_data,
    input  logic                      i_func,
    input  logic [ADDR_BITS-1:0]      i_sync_address,
    input  logic [FRAME_BITS-1:0]     i_frame_word,
    input  logic                      i_predicting_now,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_predict_valid,
    output logic [FRAME_BITS-1:0]     o_predicted_word,
    output logic                      o_show_valid,
    output logic [FRAME_BITS-1:0]     o_show_word
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CYC_W = scp_pkg::CYC_W;

    // sync table, logical entry l lives at (base + l) mod depth
    logic [ADDR_BITS-1:0]  r_addr_mem  [TABLE_DEPTH];
    logic [FRAME_BITS-1:0] r_frame_mem [TABLE_DEPTH];

    logic [scp_pkg::NEED_W-1:0] r_need;
    logic                       r_func;
    logic [ADDR_BITS-1:0]       r_addr;
    logic [FRAME_BITS-1:0]      r_frame;
    logic                       r_pred;
    logic [ADDR_BITS-1:0]       r_rd_addr;
    logic [FRAME_BITS-1:0]      r_rd_frame;

    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_base,  n_base;
    logic [IDX_W-1:0] r_pos,   n_pos;
    logic             r_pos_none, n_pos_none;
    logic [CYC_W-1:0] r_cycles, n_cycles;
    logic [CNT_W-1:0] r_idx,   n_idx;
    logic             r_show,  n_show;
    logic             r_out_valid, n_out_valid;

    logic                  r_out_pv;
    logic [FRAME_BITS-1:0] r_out_pw;
    logic                  r_out_sv;
    logic [FRAME_BITS-1:0] r_out_sw;

    logic [CNT_W-1:0]      pos_ext;
    logic [CNT_W-1:0]      pos_inc;
    logic [CNT_W-1:0]      np;
    logic [CNT_W-1:0]      p_raw;
    logic [CNT_W-1:0]      p_sel;
    logic                  p_wrap;
    logic                  grow;
    logic                  pos_in;
    logic                  cyc_ge_need;
    logic                  restart;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
    logic                  aw_en;
    logic [IDX_W-1:0]      aw_idx;
    logic                  fw_en;
    logic [IDX_W-1:0]      fw_idx;
    logic [FRAME_BITS-1:0] fw_data;
    logic                  out_pv;
    logic                  out_sv;

    function automatic logic [IDX_W-1:0] f_phys(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] l);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(l);
        if (s >= SUM_W'(TABLE_DEPTH)) begin
            s = s - SUM_W'(TABLE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    always_comb begin
        pos_ext     = CNT_W'(r_pos);
        pos_inc     = pos_ext + CNT_W'(1);
        pos_in      = !r_pos_none && (pos_ext < r_count);
        cyc_ge_need = (r_cycles >= CYC_W'(r_need));

        // step along the learned ring, wrapping at the end
        if (r_pos_none || (pos_inc >= r_count)) begin
            np = '0;
        end else begin
            np = pos_inc;
        end

        // slot for an unseen address: next position, grow, or wrap when full
        p_raw  = r_pos_none ? '0 : pos_inc;
        p_wrap = (p_raw >= r_count);
        grow   = p_wrap && (r_count < CNT_W'(TABLE_DEPTH));
        if (!p_wrap) begin
            p_sel = p_raw;
        end else if (grow) begin
            p_sel = r_count;
        end else begin
            p_sel = '0;
        end

        // an empty table reads as address zero
        restart = ((pos_in ? r_rd_addr : '0) != r_addr);
    end

    // table read and write control
    always_comb begin
        rd_en   = 1'b0;
        rd_idx  = f_phys(r_base, r_idx);
        aw_en   = 1'b0;
        aw_idx  = r_base;
        fw_en   = 1'b0;
        fw_idx  = r_base;
        fw_data = '0;
        case (i_cmd)
            scp_pkg::CMD_SRCH_RD: begin
                rd_en = 1'b1;
            end
            scp_pkg::CMD_ADV_RD: begin
                rd_en  = 1'b1;
                rd_idx = f_phys(r_base, np);
            end
            scp_pkg::CMD_OUT_RD: begin
                rd_en  = 1'b1;
                rd_idx = f_phys(r_base, pos_ext);
            end
            scp_pkg::CMD_MISS: begin
                aw_en  = 1'b1;
                aw_idx = f_phys(r_base, p_sel);
                fw_en  = grow;
                fw_idx = f_phys(r_base, r_count);
            end
            scp_pkg::CMD_ADV_CHK: begin
                // restart keeps the first slot's descriptor; a never-used slot reads as zero
                aw_en = restart;
                fw_en = restart && (r_count == '0);
            end
            scp_pkg::CMD_UPD_WR: begin
                fw_en   = 1'b1;
                fw_idx  = f_phys(r_base, r_idx);
                fw_data = r_frame;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_base      = r_base;
        n_pos       = r_pos;
        n_pos_none  = r_pos_none;
        n_cycles    = r_cycles;
        n_idx       = r_idx;
        n_show      = r_show;
        n_out_valid = r_out_valid && !i_out_ready;
        case (i_cmd)
            scp_pkg::CMD_LOAD: begin
                n_idx  = '0;
                n_show = 1'b1;
            end
            scp_pkg::CMD_NEXT: begin
                n_idx = r_idx + CNT_W'(1);
            end
            scp_pkg::CMD_TRIM: begin
                // drop the entries ahead of the repeated address
                n_base     = f_phys(r_base, r_idx);
                n_count    = r_count - r_idx;
                n_pos      = '0;
                n_pos_none = 1'b0;
                n_cycles   = CYC_W'(1);
            end
            scp_pkg::CMD_MISS: begin
                n_pos      = p_sel[IDX_W-1:0];
                n_pos_none = 1'b0;
                if (grow) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            scp_pkg::CMD_UPD_SAME: begin
                n_show = !r_pred;
            end
            scp_pkg::CMD_UPD_WR, scp_pkg::CMD_UPD_CAP: begin
                if (r_cycles > CYC_W'(1)) begin
                    n_cycles = CYC_W'(1);
                end
            end
            scp_pkg::CMD_ADV_RD: begin
                n_pos      = np[IDX_W-1:0];
                n_pos_none = 1'b0;
                if (!cyc_ge_need && (np == '0) && (r_cycles < scp_pkg::CYC_MAX)) begin
                    n_cycles = r_cycles + CYC_W'(1);
                end
            end
            scp_pkg::CMD_ADV_CHK: begin
                if (restart) begin
                    n_count  = CNT_W'(1);
                    n_pos    = '0;
                    n_cycles = '0;
                end
            end
            scp_pkg::CMD_OUT: begin
                n_out_valid = 1'b1;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    assign out_pv = !r_func && cyc_ge_need;
    assign out_sv = r_func && r_show;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need      <= scp_pkg::NEED_RESET;
            r_count     <= '0;
            r_base      <= '0;
            r_pos       <= '0;
            r_pos_none  <= 1'b1;
            r_cycles    <= '0;
            r_idx       <= '0;
            r_show      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_need <= i_cfg_wr_data;
            end
            r_count     <= n_count;
            r_base      <= n_base;
            r_pos       <= n_pos;
            r_pos_none  <= n_pos_none;
            r_cycles    <= n_cycles;
            r_idx       <= n_idx;
            r_show      <= n_show;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == scp_pkg::CMD_LOAD) begin
            r_func  <= i_func;
            r_addr  <= i_sync_address;
            r_frame <= i_frame_word;
            r_pred  <= i_predicting_now;
        end
        if (i_cmd == scp_pkg::CMD_OUT) begin
            r_out_pv <= out_pv;
            r_out_pw <= (out_pv && pos_in) ? r_rd_frame : '0;
            r_out_sv <= out_sv;
            r_out_sw <= out_sv ? r_frame : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (aw_en) begin
            r_addr_mem[aw_idx] <= r_addr;
        end
        if (fw_en) begin
            r_frame_mem[fw_idx] <= fw_data;
        end
        if (rd_en) begin
            r_rd_addr  <= r_addr_mem[rd_idx];
            r_rd_frame <= r_frame_mem[rd_idx];
        end
    end

    assign o_status.is_upd     = r_func;
    assign o_status.idx_end    = (r_idx >= r_count);
    assign o_status.addr_hit   = (r_rd_addr == r_addr);
    assign o_status.frame_hit  = (r_rd_frame == r_frame);
    assign o_status.cyc_active = cyc_ge_need || (r_cycles != '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_predict_valid  = r_out_pv;
    assign o_predicted_word = r_out_pw;
    assign o_show_valid     = r_out_sv;
    assign o_show_word      = r_out_sw;

endmodule

// ===== rtl/swapchain_cycle_predictor.sv =====
// Swapchain cycle predictor: learns the sync address order and predicts frame descriptors.
//
// Input stream (s_axis): tuser selects the item kind, 0 = predict request, 1 = rendered
// frame update. tdata carries the sync address, the frame descriptor and the
// predicting-now flag. Every item yields exactly one result item on m_axis carrying
// predict_valid/predicted_word (live for predict) and show_valid/show_word (live for
// update); the fields of the other kind read as zero.
// From input accept to result valid, a predict item on a learned cycle steps through
// S_DISP, S_ADV, S_CHK, S_OUTRD and S_OUT; any other item scans the table from S_DISP
// until a hit or the end, then goes through S_OUTRD and S_OUT. One item is in work at
// a time: the next item is taken only after the result moves to the output register.
// The sync table has a single read port; the scan reads each entry, then compares it.
// A finished result sits in the output register; the next item is accepted meanwhile,
// and only the hand-off of a following result waits while m_axis_tready is low.
// Reset (i_rst_n low, synchronous) empties the table, clears the cycle count and loads
// a threshold of three clean cycles. i_cfg_wr_en/i_cfg_wr_data write the threshold;
// write it only while no item is in work.
module swapchain_cycle_predictor #(
    parameter int TABLE_DEPTH = scp_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_BITS   = scp_pkg::ADDR_BITS_DEF,
    parameter int FRAME_BITS  = scp_pkg::FRAME_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [scp_pkg::NEED_W-1:0] i_cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // sync_address, frame_word, predicting_now (low to high), zero padded
    input  logic [((ADDR_BITS+FRAME_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // predict_valid, predicted_word, show_valid, show_word (low to high), zero padded
    output logic [((2*FRAME_BITS+2+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_W = ((2 * FRAME_BITS + 2 + 7) / 8) * 8;

    scp_pkg::t_cmd       cmd;
    scp_pkg::t_dp_status status;

    logic                  predict_valid;
    logic [FRAME_BITS-1:0] predicted_word;
    logic                  show_valid;
    logic [FRAME_BITS-1:0] show_word;

    scp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    scp_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BITS   (ADDR_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_func           (s_axis_tuser),
        .i_sync_address   (s_axis_tdata[ADDR_BITS-1:0]),
        .i_frame_word     (s_axis_tdata[ADDR_BITS +: FRAME_BITS]),
        .i_predicting_now (s_axis_tdata[ADDR_BITS+FRAME_BITS]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_predict_valid  (predict_valid),
        .o_predicted_word (predicted_word),
        .o_show_valid     (show_valid),
        .o_show_word      (show_word)
    );

    assign m_axis_tdata = OUT_W'({show_word, show_valid, predicted_word, predict_valid});

endmodule

// ===== rtl/scp_checker.sv =====
// Port-level checker of the swapchain cycle predictor, bound to the top level.
`include "swapchain_cycle_predictor_assert.svh"

module scp_checker #(
    parameter int FRAME_BITS = scp_pkg::FRAME_BITS_DEF,
    parameter int OUT_W      = ((2 * scp_pkg::FRAME_BITS_DEF + 2 + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    `SCP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result item changed or dropped")

    `SCP_ASSERT_NEXT(a_one_in_work, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while one is in work")

    `SCP_ASSERT_NOW(a_one_kind, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[FRAME_BITS+1]), "result flags both predict and show")

    `SCP_ASSERT_NOW(a_pred_clear, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[FRAME_BITS:1] == '0, "predicted word not zero without predict_valid")

    `SCP_ASSERT_NOW(a_show_clear, m_axis_tvalid && !m_axis_tdata[FRAME_BITS+1], m_axis_tdata[2*FRAME_BITS+1:FRAME_BITS+2] == '0, "show word not zero without show_valid")

endmodule

bind swapchain_cycle_predictor scp_checker #(
    .FRAME_BITS (FRAME_BITS),
    .OUT_W      (OUT_W)
) u_scp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/scp_frame_checker.sv =====
// Checker for the swapchain cycle predictor: tracks the sync table and compares each result.
module scp_frame_checker #(
    parameter int DEPTH   = scp_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W  = scp_pkg::ADDR_BITS_DEF,
    parameter int FRAME_W = scp_pkg::FRAME_BITS_DEF,
    parameter int IN_W    = ((ADDR_W + FRAME_W + 1 + 7) / 8) * 8,
    parameter int OUT_W   = ((2 * FRAME_W + 2 + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [scp_pkg::NEED_W-1:0] i_cfg_wr_data,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    // sync_address, frame_word, predicting_now (low to high), zero padded
    input  logic [IN_W-1:0]            s_axis_tdata,
    // func
    input  logic                       s_axis_tuser,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // predict_valid, predicted_word, show_valid, show_word (low to high), zero padded
    input  logic [OUT_W-1:0]           m_axis_tdata,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic               pred_ok;
        logic [FRAME_W-1:0] pred_word;
        logic               show_ok;
        logic [FRAME_W-1:0] show_word;
    } t_frame_result;

    localparam int unsigned MAX_CLEAN = 32'(scp_pkg::CYC_MAX);
    localparam int          REPORT_LIMIT = 10;

    logic [ADDR_W-1:0]  slot_addr  [DEPTH];
    logic [FRAME_W-1:0] slot_frame [DEPTH];
    int unsigned        slot_count;
    int unsigned        cur_pos;
    int unsigned        clean_cycles;
    int unsigned        cycles_needed;
    t_frame_result      frame_results_due [$];
    int                 mismatches;

    function automatic logic [FRAME_W-1:0] frame_in_slot(input int unsigned pos);
        if (pos < slot_count && pos < DEPTH) begin
            return slot_frame[pos];
        end
        return '0;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_in_slot(input int unsigned pos);
        if (pos < slot_count && pos < DEPTH) begin
            return slot_addr[pos];
        end
        return '0;
    endfunction

    function automatic int unsigned next_pos(input int unsigned pos);
        int unsigned n;
        n = pos + 1;
        if (n >= slot_count) begin
            n = 0;
        end
        return n;
    endfunction

    // Drop the learned cycle and keep one entry with the new address.
    function automatic void restart_from(input logic [ADDR_W-1:0] addr);
        slot_count   = 1;
        slot_addr[0] = addr;
        cur_pos      = 0;
        clean_cycles = 0;
    endfunction

    function automatic void learn_address(input logic [ADDR_W-1:0] addr);
        int unsigned i;
        int unsigned k;
        bit          hit;
        hit = 1'b0;
        if (clean_cycles >= cycles_needed) begin
            cur_pos = next_pos(cur_pos);
            if (addr_in_slot(cur_pos) != addr) begin
                restart_from(addr);
            end
        end else if (clean_cycles >= 1) begin
            cur_pos = next_pos(cur_pos);
            if (cur_pos == 0 && clean_cycles < MAX_CLEAN) begin
                clean_cycles++;
            end
            if (addr_in_slot(cur_pos) != addr) begin
                restart_from(addr);
            end
        end else begin
            // Scan for a repeat; trim the table so that it starts at the hit.
            for (i = 0; i < slot_count && i < DEPTH && !hit; i++) begin
                if (slot_addr[i] == addr) begin
                    for (k = 0; k + i < slot_count && k + i < DEPTH; k++) begin
                        slot_addr[k]  = slot_addr[k + i];
                        slot_frame[k] = slot_frame[k + i];
                    end
                    slot_count   = slot_count - i;
                    cur_pos      = 0;
                    clean_cycles = 1;
                    hit          = 1'b1;
                end
            end
            if (!hit) begin
                cur_pos = (cur_pos + 1) & 32'hFF;
                if (cur_pos >= slot_count) begin
                    if (slot_count >= DEPTH) begin
                        cur_pos = 0;
                    end else begin
                        cur_pos                = slot_count;
                        slot_frame[slot_count] = '0;
                        slot_count++;
                    end
                end
                if (cur_pos < DEPTH) begin
                    slot_addr[cur_pos] = addr;
                end
            end
        end
    endfunction

    function automatic t_frame_result predict_frame_result(
        input logic               is_update,
        input logic [ADDR_W-1:0]  addr,
        input logic [FRAME_W-1:0] frame,
        input logic               on_pred
    );
        t_frame_result res;
        int unsigned   i;
        bit            want_show;
        bit            found;
        bit            same;
        res = '0;
        if (!is_update) begin
            learn_address(addr);
            if (clean_cycles >= cycles_needed) begin
                res.pred_ok   = 1'b1;
                res.pred_word = frame_in_slot(cur_pos);
            end
        end else begin
            want_show = !on_pred;
            found     = 1'b0;
            same      = 1'b0;
            for (i = 0; i < slot_count && i < DEPTH && !found; i++) begin
                if (slot_addr[i] == addr) begin
                    if (slot_frame[i] == frame) begin
                        same = 1'b1;
                    end else begin
                        slot_frame[i] = frame;
                    end
                    found = 1'b1;
                end
            end
            // A frame that was already stored leaves the cycle count alone.
            if (!same) begin
                if (on_pred) begin
                    want_show = 1'b1;
                end
                if (clean_cycles > 1) begin
                    clean_cycles = 1;
                end
            end
            if (want_show) begin
                res.show_ok   = 1'b1;
                res.show_word = frame;
            end
        end
        return res;
    endfunction

    function automatic void log_mismatch(input t_frame_result want, input t_frame_result got,
                                         input bit unexpected);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            if (unexpected) begin
                $display("%0t: result with nothing pending: pv=%0b pw=%h sv=%0b sw=%h",
                         $time, got.pred_ok, got.pred_word, got.show_ok, got.show_word);
            end else begin
                $display("%0t: result mismatch: expected pv=%0b pw=%h sv=%0b sw=%h",
                         $time, want.pred_ok, want.pred_word, want.show_ok, want.show_word);
                $display("%0t:                   actual pv=%0b pw=%h sv=%0b sw=%h",
                         $time, got.pred_ok, got.pred_word, got.show_ok, got.show_word);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        int            i;
        if (!i_rst_n) begin
            for (i = 0; i < DEPTH; i++) begin
                slot_addr[i]  = '0;
                slot_frame[i] = '0;
            end
            slot_count    = 0;
            cur_pos       = 32'hFF;
            clean_cycles  = 0;
            cycles_needed = 32'(scp_pkg::NEED_RESET);
            mismatches    = 0;
            frame_results_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                cycles_needed = 32'(i_cfg_wr_data);
            end
            // Retire the result first: it never belongs to an item taken at this edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got.pred_ok   = m_axis_tdata[0];
                got.pred_word = m_axis_tdata[FRAME_W:1];
                got.show_ok   = m_axis_tdata[FRAME_W+1];
                got.show_word = m_axis_tdata[2*FRAME_W+1:FRAME_W+2];
                if (frame_results_due.size() == 0) begin
                    log_mismatch(got, got, 1'b1);
                end else begin
                    want = frame_results_due.pop_front();
                    if (got.pred_ok !== want.pred_ok || got.pred_word !== want.pred_word ||
                        got.show_ok !== want.show_ok || got.show_word !== want.show_word) begin
                        log_mismatch(want, got, 1'b0);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                // Queue the expected result behind the ones still due.
                frame_results_due.insert(frame_results_due.size(), predict_frame_result(
                    s_axis_tuser,
                    s_axis_tdata[ADDR_W-1:0],
                    s_axis_tdata[ADDR_W+FRAME_W-1:ADDR_W],
                    s_axis_tdata[ADDR_W+FRAME_W]));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= frame_results_due.size();
    end

endmodule

// ===== sim/tb_swapchain_cycle_predictor.sv =====
// Testbench top for the swapchain cycle predictor: stimulus, flow control and verdict.
module tb_swapchain_cycle_predictor;

    localparam int DEPTH   = scp_pkg::TABLE_DEPTH_DEF;
    localparam int ADDR_W  = scp_pkg::ADDR_BITS_DEF;
    localparam int FRAME_W = scp_pkg::FRAME_BITS_DEF;
    localparam int IN_W    = ((ADDR_W + FRAME_W + 1 + 7) / 8) * 8;
    localparam int OUT_W   = ((2 * FRAME_W + 2 + 7) / 8) * 8;

    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;

    localparam int SEGMENTS        = 12;
    localparam int SEGMENT_ITEMS   = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 2 * DEPTH + 20;

    logic                       i_clk;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_wr_en   = 1'b0;
    logic [scp_pkg::NEED_W-1:0] i_cfg_wr_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_W-1:0]            s_axis_tdata  = '0;
    logic                       s_axis_tuser  = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_W-1:0]           m_axis_tdata;

    int fail_count;
    int pending;
    int src_idle_pct = 10;
    int snk_idle_pct = 75;
    bit hold_off_req = 1'b0;
    int need_now     = scp_pkg::NEED_RESET;

    swapchain_cycle_predictor #(
        .TABLE_DEPTH (DEPTH),
        .ADDR_BITS   (ADDR_W),
        .FRAME_BITS  (FRAME_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    scp_frame_checker #(
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W),
        .FRAME_W (FRAME_W)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [FRAME_W-1:0] rnd_frame();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] rnd_addr();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic offer_item(input logic func, input logic [ADDR_W-1:0] addr,
                              input logic [FRAME_W-1:0] frame, input logic on_pred);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= IN_W'({on_pred, frame, addr});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(input int need);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= scp_pkg::NEED_W'(need);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        need_now = need;
    endtask

    // Mostly repeating swapchains with matching updates; the rest is noise.
    task automatic run_swapchains(input int n_items);
        logic [ADDR_W-1:0]  ring  [8];
        logic [FRAME_W-1:0] drawn [8];
        logic [ADDR_W-1:0]  pool  [4];
        int                 sent;
        int                 len;
        int                 laps;
        int                 lap;
        int                 j;
        logic               on_pred;
        for (j = 0; j < 4; j++) begin
            pool[j] = rnd_addr();
        end
        for (j = 0; j < 8; j++) begin
            ring[j]  = rnd_addr();
            drawn[j] = rnd_frame();
        end
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 80) begin
                // Lengths past the table depth wrap the ring over old slots.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH + 1, 8)
                                                  : $urandom_range(1, DEPTH);
                for (j = 0; j < len; j++) begin
                    ring[j]  = ($urandom_range(0, 9) == 0) ? pool[$urandom_range(0, 3)]
                                                           : rnd_addr();
                    drawn[j] = rnd_frame();
                end
                laps = $urandom_range(2, 10);
                for (lap = 0; lap < laps && sent < n_items; lap++) begin
                    for (j = 0; j < len && sent < n_items; j++) begin
                        if ($urandom_range(0, 99) < 3) begin
                            offer_item(FUNC_PREDICT, rnd_addr(), rnd_frame(), 1'($urandom));
                        end else begin
                            offer_item(FUNC_PREDICT, ring[j], rnd_frame(), 1'($urandom));
                        end
                        sent++;
                        if ($urandom_range(0, 4) != 0) begin
                            if ($urandom_range(0, 9) == 0) begin
                                drawn[j] = rnd_frame();
                            end
                            on_pred = (lap > need_now) ^ ($urandom_range(0, 9) == 0);
                            offer_item(FUNC_UPDATE, ring[j], drawn[j], on_pred);
                            sent++;
                        end
                    end
                end
            end else begin
                offer_item(1'($urandom),
                           $urandom_range(0, 1) ? ring[$urandom_range(0, 7)] : rnd_addr(),
                           $urandom_range(0, 1) ? drawn[$urandom_range(0, 7)] : rnd_frame(),
                           1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        logic [ADDR_W-1:0]  addr_a;
        logic [ADDR_W-1:0]  addr_b;
        logic [ADDR_W-1:0]  addr_c;
        logic [FRAME_W-1:0] frame_c;
        int                 need_plan [SEGMENTS];
        int                 seg;
        int                 rep;
        need_plan = '{1, 7, 0, 2, 5, 3, 6, 4, 7, 1, 2, 3};
        addr_a  = '0;
        addr_b  = '1;
        addr_c  = $urandom;
        frame_c = {$urandom, $urandom};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero threshold on an empty table, then a miss on the single entry.
        write_threshold(0);
        offer_item(FUNC_PREDICT, addr_b, '0, 1'b0);
        offer_item(FUNC_PREDICT, addr_a, '1, 1'b1);
        write_threshold(scp_pkg::NEED_RESET);

        offer_item(FUNC_UPDATE, addr_a, '1, 1'b1);
        offer_item(FUNC_PREDICT, addr_b, '1, 1'b1);
        offer_item(FUNC_PREDICT, addr_c, frame_c, 1'b0);
        offer_item(FUNC_UPDATE, addr_b, '0, 1'b0);
        offer_item(FUNC_UPDATE, addr_c, frame_c, 1'b0);
        // Learn the A, B, C order until predictions come out.
        for (rep = 0; rep < 3; rep++) begin
            offer_item(FUNC_PREDICT, addr_a, '0, 1'b0);
            offer_item(FUNC_PREDICT, addr_b, '0, 1'b0);
            offer_item(FUNC_PREDICT, addr_c, '0, 1'b0);
        end
        offer_item(FUNC_UPDATE, addr_c, frame_c, 1'b1);
        offer_item(FUNC_PREDICT, addr_a, '0, 1'b0);
        offer_item(FUNC_UPDATE, addr_a, {$urandom, $urandom}, 1'b1);
        offer_item(FUNC_PREDICT, addr_c, '0, 1'b0);
        offer_item(FUNC_UPDATE, 32'h8000_0001, {$urandom, $urandom}, 1'b0);
        offer_item(FUNC_PREDICT, addr_a, '1, 1'b1);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < 4) begin
                src_idle_pct = 10;
                snk_idle_pct = 75;
            end else if (seg < 8) begin
                src_idle_pct = 75;
                snk_idle_pct = 10;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_threshold(need_plan[seg]);
            if (seg == 8) begin
                hold_off_req = 1'b1;
            end
            run_swapchains(SEGMENT_ITEMS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/scp_pkg.sv
rtl/scp_ctrl.sv
rtl/scp_dpath.sv
rtl/swapchain_cycle_predictor.sv
rtl/scp_checker.sv
sim/scp_frame_checker.sv
sim/tb_swapchain_cycle_predictor.sv
